@@ src/khash_pkg.sv @@
// Shared constants and types of the k-mer counting hash table.
package khash_pkg;

	// Result field widths
	localparam int STATUS_W = 3;
	localparam int BUCKET_W = 14;
	localparam int COUNT_W  = 8;
	localparam int PROBES_W = 9;
	localparam int MAXP_W   = 8;
	localparam int LOG2_W   = 4;
	localparam int CFG_IDX_W = 1;

	// Parameter defaults
	localparam int TABLE_DEPTH_DEF = 16384;
	localparam int KEY_WIDTH_DEF   = 62;

	// Count saturation and smallest table size
	localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;
	localparam logic [LOG2_W-1:0]  LOG2_MIN  = 4'd4;

	// Register reset values
	localparam logic [MAXP_W-1:0] MAXP_RST = 8'd62;
	localparam logic [LOG2_W-1:0] LOG2_RST = 4'd14;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PROBES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LOG2 = 1'b1;

	// Operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_NEW      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_COUNTED  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

	// One result item
	typedef struct packed {
		logic [PROBES_W-1:0] probes;
		logic [COUNT_W-1:0]  count;
		logic [BUCKET_W-1:0] bucket;
		logic [STATUS_W-1:0] status;
	} res_t;

endpackage

@@ src/khash_mem.sv @@
// Table memory: key store and count store, one write port, one registered read port.
module khash_mem #(
	parameter int DEPTH = khash_pkg::TABLE_DEPTH_DEF,
	parameter int KEY_W = khash_pkg::KEY_WIDTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                         clk,
	input  logic [AW-1:0]                rd_addr,
	output logic [KEY_W-1:0]             rd_key,
	output logic [khash_pkg::COUNT_W-1:0] rd_cnt,
	input  logic                         we,
	input  logic [AW-1:0]                wr_addr,
	input  logic [KEY_W-1:0]             wr_key,
	input  logic [khash_pkg::COUNT_W-1:0] wr_cnt
);

	logic [KEY_W-1:0]              key_mem [DEPTH];
	logic [khash_pkg::COUNT_W-1:0] cnt_mem [DEPTH];

	// Write key and count together
	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[wr_addr] <= wr_key;
			cnt_mem[wr_addr] <= wr_cnt;
		end
	end

	// Read every cycle, data registered
	always_ff @(posedge clk) begin
		rd_key <= key_mem[rd_addr];
		rd_cnt <= cnt_mem[rd_addr];
	end

endmodule

@@ src/khash_seq.sv @@
// Probe sequencer: clearing pass, linear probe walk with one key compare per cycle.
module khash_seq #(
	parameter int DEPTH = khash_pkg::TABLE_DEPTH_DEF,
	parameter int KEY_W = khash_pkg::KEY_WIDTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input item
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          in_op,
	input  logic [KEY_W-1:0]              in_key,
	// Settings
	input  logic [AW-1:0]                 slot_mask,
	input  logic [khash_pkg::PROBES_W-1:0] limit,
	// Table memory
	output logic [AW-1:0]                 rd_addr,
	input  logic [KEY_W-1:0]              rd_key,
	input  logic [khash_pkg::COUNT_W-1:0] rd_cnt,
	output logic                          we,
	output logic [AW-1:0]                 wr_addr,
	output logic [KEY_W-1:0]              wr_key,
	output logic [khash_pkg::COUNT_W-1:0] wr_cnt,
	// Result
	output logic                          res_valid,
	input  logic                          res_ready,
	output khash_pkg::res_t               res
);

	localparam logic [1:0] S_CLR   = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_PROBE = 2'd2;
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	logic [1:0]                     state_q;
	logic [AW-1:0]                  clr_q;
	logic [AW-1:0]                  slot_q;
	logic [KEY_W-1:0]               key_q;
	logic                           op_q;
	logic [khash_pkg::PROBES_W-1:0] probes_q;

	logic                           accept;
	logic                           empty;
	logic                           match;
	logic                           at_limit;
	logic                           done;
	logic                           commit;
	logic [khash_pkg::PROBES_W-1:0] probes_n;
	logic [AW-1:0]                  slot_n;
	logic [khash_pkg::COUNT_W-1:0]  cnt_inc;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// Compare unit
	assign empty    = (rd_cnt == '0);
	assign match    = (rd_key == key_q);
	assign probes_n = probes_q + 9'd1;
	assign at_limit = (probes_n == limit);
	assign slot_n   = (slot_q + AW'(1)) & slot_mask;
	assign cnt_inc  = (rd_cnt == khash_pkg::COUNT_MAX) ? rd_cnt : rd_cnt + 8'd1;
	assign done     = (state_q == S_PROBE) && (empty || match || at_limit);
	assign res_valid = done;
	assign commit   = done && res_ready && (op_q == khash_pkg::OP_INSERT) && (empty || match);

	// Pick the slot read next; hold the current slot while the result stalls
	always_comb begin
		case (state_q)
			S_IDLE:  rd_addr = AW'(in_key) & slot_mask;
			S_PROBE: rd_addr = done ? slot_q : slot_n;
			default: rd_addr = slot_q;
		endcase
	end

	// Write port: clearing pass or claim/count
	always_comb begin
		we      = 1'b0;
		wr_addr = slot_q;
		wr_key  = key_q;
		wr_cnt  = empty ? 8'd1 : cnt_inc;
		if (state_q == S_CLR) begin
			we      = 1'b1;
			wr_addr = clr_q;
			wr_cnt  = '0;
		end else if (commit) begin
			we = 1'b1;
		end
	end

	// Build the result
	always_comb begin
		res.probes = probes_n;
		res.bucket = '0;
		res.count  = '0;
		if (op_q == khash_pkg::OP_LOOKUP) begin
			res.status = khash_pkg::ST_NOTFOUND;
		end else begin
			res.status = khash_pkg::ST_FULL;
		end
		if (empty) begin
			if (op_q == khash_pkg::OP_INSERT) begin
				res.status = khash_pkg::ST_NEW;
				res.bucket = khash_pkg::BUCKET_W'(slot_q);
				res.count  = 8'd1;
			end
		end else if (match) begin
			res.bucket = khash_pkg::BUCKET_W'(slot_q);
			if (op_q == khash_pkg::OP_INSERT) begin
				res.status = khash_pkg::ST_COUNTED;
				res.count  = cnt_inc;
			end else begin
				res.status = khash_pkg::ST_FOUND;
				res.count  = rd_cnt;
			end
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_ADDR) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) state_q <= S_PROBE;
				end
				S_PROBE: begin
					if (done && res_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Item registers: latch on accept, advance one slot per probe
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q    <= in_key;
			op_q     <= in_op;
			slot_q   <= AW'(in_key) & slot_mask;
			probes_q <= '0;
		end else if ((state_q == S_PROBE) && !done) begin
			slot_q   <= slot_n;
			probes_q <= probes_n;
		end
	end

endmodule

@@ src/kmer_counting_hash_table.sv @@
// An item with P probes (1 to max_probes+1) shows its result through the output register.
// One item at a time, after the last result is handed on; the probe walk reads one slot per cycle.
// A finished result waits in the output register while the next item is taken.
// Reset: asynchronous, active low; max_probes returns to 62, table_size_log2 to 14.
// After reset a clearing pass zeroes every slot of the count store, with no item taken.
// TABLE_DEPTH must be a power of two.
module kmer_counting_hash_table #(
	parameter int TABLE_DEPTH = khash_pkg::TABLE_DEPTH_DEF,
	parameter int KEY_WIDTH   = khash_pkg::KEY_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration
	input  logic                            cfg_we,
	input  logic [khash_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [khash_pkg::MAXP_W-1:0]    cfg_data,
	// Input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [((KEY_WIDTH+7)/8)*8-1:0]  s_tdata,  // kmer, zero pad
	input  logic                            s_tuser,  // opcode
	// Output stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [31:0]                     m_tdata,  // bucket, count, probes, zero pad
	output logic [khash_pkg::STATUS_W-1:0]  m_tuser   // status
);

	localparam int AW = $clog2(TABLE_DEPTH);

	logic [khash_pkg::MAXP_W-1:0]   max_probes_q;
	logic [khash_pkg::LOG2_W-1:0]   table_log2_q;
	logic [khash_pkg::LOG2_W-1:0]   lg_eff;
	logic [AW-1:0]                  slot_mask;
	logic [khash_pkg::PROBES_W-1:0] limit;

	logic [AW-1:0]                  rd_addr;
	logic [KEY_WIDTH-1:0]           rd_key;
	logic [khash_pkg::COUNT_W-1:0]  rd_cnt;
	logic                           we;
	logic [AW-1:0]                  wr_addr;
	logic [KEY_WIDTH-1:0]           wr_key;
	logic [khash_pkg::COUNT_W-1:0]  wr_cnt;

	logic                           res_valid;
	logic                           res_ready;
	khash_pkg::res_t                res;
	khash_pkg::res_t                out_q;
	logic                           out_valid_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_probes_q <= khash_pkg::MAXP_RST;
			table_log2_q <= khash_pkg::LOG2_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				khash_pkg::CFG_MAX_PROBES: max_probes_q <= cfg_data;
				khash_pkg::CFG_TABLE_LOG2: table_log2_q <= cfg_data[khash_pkg::LOG2_W-1:0];
				default: ;
			endcase
		end
	end

	// Slot mask: at least 16 slots, at most the whole memory
	assign lg_eff = (table_log2_q < khash_pkg::LOG2_MIN) ? khash_pkg::LOG2_MIN : table_log2_q;
	always_comb begin
		for (int i = 0; i < AW; i++) begin
			slot_mask[i] = (i < int'(lg_eff));
		end
	end
	assign limit = {1'b0, max_probes_q} + 9'd1;

	khash_mem #(
		.DEPTH (TABLE_DEPTH),
		.KEY_W (KEY_WIDTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.rd_addr (rd_addr),
		.rd_key  (rd_key),
		.rd_cnt  (rd_cnt),
		.we      (we),
		.wr_addr (wr_addr),
		.wr_key  (wr_key),
		.wr_cnt  (wr_cnt)
	);

	khash_seq #(
		.DEPTH (TABLE_DEPTH),
		.KEY_W (KEY_WIDTH),
		.AW    (AW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (s_tuser),
		.in_key    (s_tdata[KEY_WIDTH-1:0]),
		.slot_mask (slot_mask),
		.limit     (limit),
		.rd_addr   (rd_addr),
		.rd_key    (rd_key),
		.rd_cnt    (rd_cnt),
		.we        (we),
		.wr_addr   (wr_addr),
		.wr_key    (wr_key),
		.wr_cnt    (wr_cnt),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register: load when empty or being drained
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {1'b0, out_q.probes, out_q.count, out_q.bucket};

endmodule

@@ src/khash_chk.sv @@
// Port checker for the k-mer counting hash table, bound to the top level.
module khash_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [31:0]                    m_tdata,
	input logic [khash_pkg::STATUS_W-1:0] m_tuser
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// One item at a time: no transfer in the cycle after a transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while probing");

	// Absent or full results carry no bucket and no count
	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == khash_pkg::ST_NOTFOUND || m_tuser == khash_pkg::ST_FULL)
		|-> m_tdata[21:0] == 22'd0)
		else $error("absent result with bucket or count");

	// A fresh insert has count one and at least one probe
	a_new_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == khash_pkg::ST_NEW |-> m_tdata[21:14] == 8'd1 && m_tdata[30:22] != 9'd0)
		else $error("new entry with wrong count or no probe");

endmodule

bind kmer_counting_hash_table khash_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

@@ tb/kmer_table_checker.sv @@
// Result checker for the k-mer counting hash table: tracks the table, predicts and compares.
`timescale 1ns / 100ps

module kmer_table_checker (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         cfg_we,
	input  logic [khash_pkg::CFG_IDX_W-1:0]              cfg_index,
	input  logic [khash_pkg::MAXP_W-1:0]                 cfg_data,
	input  logic                                         s_tvalid,
	input  logic                                         s_tready,
	input  logic [((khash_pkg::KEY_WIDTH_DEF+7)/8)*8-1:0] s_tdata,  // kmer, zero pad
	input  logic                                         s_tuser,  // opcode
	input  logic                                         m_tvalid,
	input  logic                                         m_tready,
	input  logic [31:0]                                  m_tdata,  // bucket, count, probes, zero pad
	input  logic [khash_pkg::STATUS_W-1:0]               m_tuser,  // status
	output int                                           fail_count,
	output int                                           pending
);
	import khash_pkg::*;

	localparam int DEPTH = TABLE_DEPTH_DEF;
	localparam int KEY_W = KEY_WIDTH_DEF;

	// Shadow copy of the table and its registers
	logic [KEY_W-1:0]   key_slots [DEPTH];
	logic [COUNT_W-1:0] count_slots [DEPTH];
	logic [MAXP_W-1:0]  probe_limit_reg;
	logic [LOG2_W-1:0]  size_log2_reg;

	res_t awaited_results [$];
	int   mismatches;

	// Walk the probe sequence for one item, update the shadow table and return the result
	function automatic res_t walk_probe_sequence(input logic op, input logic [KEY_W-1:0] key);
		int unsigned lg, slots, slot, limit, n;
		res_t r;
		lg = size_log2_reg;
		if (lg < LOG2_MIN) begin
			lg = LOG2_MIN;
		end
		slots = 1 << lg;
		if (slots > DEPTH) begin
			slots = DEPTH;
		end
		slot = 32'(key) & (slots - 1);
		limit = probe_limit_reg + 1;
		r.status = (op == OP_LOOKUP) ? ST_NOTFOUND : ST_FULL;
		r.bucket = '0;
		r.count = '0;
		n = 0;
		while (n < limit) begin
			n++;
			// empty slot ends the walk; an insert claims it
			if (count_slots[slot] == '0) begin
				if (op == OP_INSERT) begin
					key_slots[slot] = key;
					count_slots[slot] = 8'd1;
					r.status = ST_NEW;
					r.bucket = BUCKET_W'(slot);
					r.count = 8'd1;
				end
				break;
			end
			// matching key: count it or report it
			if (key_slots[slot] == key) begin
				if (op == OP_INSERT) begin
					if (count_slots[slot] != COUNT_MAX) begin
						count_slots[slot] = count_slots[slot] + 8'd1;
					end
					r.status = ST_COUNTED;
				end else begin
					r.status = ST_FOUND;
				end
				r.bucket = BUCKET_W'(slot);
				r.count = count_slots[slot];
				break;
			end
			slot = (slot + 1) & (slots - 1);
		end
		r.probes = PROBES_W'(n);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t got, want;
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				count_slots[i] = '0;
			end
			probe_limit_reg = MAXP_RST;
			size_log2_reg = LOG2_RST;
			awaited_results.delete();
			mismatches = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			// compare a result transfer with the oldest prediction; status sits lowest
			if (m_tvalid && m_tready) begin
				got = {m_tdata[PROBES_W+COUNT_W+BUCKET_W-1:0], m_tuser};
				if (awaited_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected result: status %0d bucket %0d count %0d probes %0d",
							got.status, got.bucket, got.count, got.probes);
					end
				end else begin
					want = awaited_results.pop_front();
					if (got.status !== want.status || got.bucket !== want.bucket ||
							got.count !== want.count || got.probes !== want.probes) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: expected status %0d bucket %0d count %0d probes %0d",
								want.status, want.bucket, want.count, want.probes);
							$display("          got      status %0d bucket %0d count %0d probes %0d",
								got.status, got.bucket, got.count, got.probes);
						end
					end
				end
			end
			// follow register writes
			if (cfg_we) begin
				case (cfg_index)
					CFG_MAX_PROBES: probe_limit_reg = cfg_data;
					CFG_TABLE_LOG2: size_log2_reg = cfg_data[LOG2_W-1:0];
					default: ;
				endcase
			end
			// predict each input transfer
			if (s_tvalid && s_tready) begin
				awaited_results.push_back(walk_probe_sequence(s_tuser, s_tdata[KEY_W-1:0]));
			end
			fail_count <= mismatches;
			pending <= awaited_results.size();
		end
	end

endmodule

@@ tb/kmer_counting_hash_table_test.sv @@
// Testbench top for the k-mer counting hash table: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module kmer_counting_hash_table_test;
	import khash_pkg::*;

	localparam int KEY_W   = KEY_WIDTH_DEF;
	localparam int TDATA_W = ((KEY_WIDTH_DEF + 7) / 8) * 8;
	localparam int POOL_N  = 32;
	localparam logic [KEY_W-1:0] ALL_ONES_KEY = '1;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [MAXP_W-1:0]    cfg_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [TDATA_W-1:0]   s_tdata = '0;  // kmer, zero pad
	logic                 s_tuser = 1'b0;  // opcode
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [31:0]          m_tdata;  // bucket, count, probes, zero pad
	logic [STATUS_W-1:0]  m_tuser;  // status
	int                   fail_count;
	int                   pending;
	bit                   tx_calm = 1'b0;

	kmer_counting_hash_table uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	kmer_table_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.fail_count(fail_count), .pending(pending)
	);

	always #10 clk = ~clk;

	// Stop a hung run
	initial begin
		#30_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Result side: stall a random number of cycles before each transfer, in bursts
	initial begin
		int gap;
		int served;
		bit stalls;
		served = 0;
		stalls = 1'b1;
		forever begin
			if (served % 32 == 0) begin
				stalls = ($urandom_range(0, 3) != 0);
			end
			gap = stalls ? $urandom_range(0, 15) : 0;
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			served++;
		end
	end

	function automatic logic [KEY_W-1:0] fresh_key();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[KEY_W-1:0];
	endfunction

	// Present one item after a random gap and hold it until its transfer
	task automatic send_item(input logic op, input logic [KEY_W-1:0] key);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(TDATA_W - KEY_W){1'b0}}, key};
		s_tuser <= op;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Drop valid and hold until every predicted result has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Write both registers; call only while idle
	task automatic set_config(input logic [MAXP_W-1:0] maxp, input logic [MAXP_W-1:0] lg);
		cfg_we <= 1'b1;
		cfg_index <= CFG_MAX_PROBES;
		cfg_data <= maxp;
		@(posedge clk);
		cfg_index <= CFG_TABLE_LOG2;
		cfg_data <= lg;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random traffic on one register setting: a key pool with colliding start buckets,
	// optionally dominated by one hot key that saturates its count
	task automatic run_phase(input logic [MAXP_W-1:0] maxp, input logic [LOG2_W-1:0] lg,
			input int n_items, input bit hot);
		logic [KEY_W-1:0] pool [POOL_N];
		logic [KEY_W-1:0] hot_key;
		logic [KEY_W-1:0] key;
		logic op;
		int pick;
		drain();
		set_config(maxp, {4'($urandom_range(0, 15)), lg});
		hot_key = fresh_key();
		for (int i = 0; i < POOL_N; i++) begin
			pool[i] = fresh_key();
			if ($urandom_range(0, 1) != 0) begin
				pool[i][7:0] = 8'($urandom_range(0, 7));
			end
		end
		for (int i = 0; i < n_items; i++) begin
			if (i % 40 == 0) begin
				tx_calm = ($urandom_range(0, 3) == 0);
			end
			pick = $urandom_range(0, 99);
			op = ($urandom_range(0, 9) < 6) ? OP_INSERT : OP_LOOKUP;
			if (hot && pick < 80) begin
				key = hot_key;
				op = OP_INSERT;
			end else if (hot && pick < 85) begin
				key = hot_key;
				op = OP_LOOKUP;
			end else if (hot || pick < 75) begin
				key = pool[$urandom_range(0, POOL_N - 1)];
			end else begin
				key = fresh_key();
			end
			// now and then let the table go idle mid-phase
			if ($urandom_range(0, 49) == 0) begin
				drain();
			end
			send_item(op, key);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setting: extreme keys, count existing, collision and wrap at the top slot
		send_item(OP_INSERT, '0);
		send_item(OP_INSERT, ALL_ONES_KEY);
		send_item(OP_INSERT, '0);
		send_item(OP_LOOKUP, '0);
		send_item(OP_LOOKUP, ALL_ONES_KEY);
		send_item(OP_LOOKUP, 62'd5);
		send_item(OP_INSERT, 62'h4000);
		send_item(OP_LOOKUP, 62'h4000);
		send_item(OP_INSERT, 62'h10_3FFF);

		// Size below range and no extra probes: a new key is full on insert and not found on lookup
		drain();
		set_config(8'd0, 8'hF0);
		send_item(OP_INSERT, 62'h10);
		send_item(OP_LOOKUP, 62'h10);
		send_item(OP_LOOKUP, 62'h4000);
		send_item(OP_INSERT, '0);

		// Size above table depth, longest probe limit
		drain();
		set_config(8'd255, 8'h0F);
		send_item(OP_LOOKUP, 62'h4000);
		send_item(OP_LOOKUP, 62'h10_3FFF);

		run_phase(8'd3, 4'd5, 150, 1'b0);
		run_phase(8'd255, 4'd4, 120, 1'b0);
		run_phase(8'd62, 4'd14, 360, 1'b1);
		run_phase(8'd0, 4'd6, 100, 1'b0);
		run_phase(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)), 220, 1'b0);

		drain();
		repeat (300) @(posedge clk);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
